// ===== design/dct_pkg.sv =====
// Shared types, constants and cosine basis for the 8x8 DCT block.
package dct_pkg;

   localparam int SAMPLE_WIDTH  = 12;
   localparam int COS_FRAC_BITS = 14;
   localparam int RESULT_WIDTH  = 16;
   localparam int BLK           = 8;
   localparam int BLK2          = 64;
   localparam int MID_WIDTH     = 19;
   localparam int COEF_WIDTH    = COS_FRAC_BITS + 2;
   localparam int ACC_WIDTH     = MID_WIDTH + COEF_WIDTH + 3;
   localparam int MULT_WIDTH    = MID_WIDTH + COEF_WIDTH;
   localparam int BIT_CNT_WIDTH = 5;

   typedef logic signed [SAMPLE_WIDTH-1:0]  sample_type;
   typedef logic signed [RESULT_WIDTH-1:0]  result_type;
   typedef logic signed [MID_WIDTH-1:0]     mid_type;
   typedef logic signed [COEF_WIDTH-1:0]    coef_type;
   typedef logic signed [ACC_WIDTH-1:0]     acc_type;

   typedef enum logic [2:0] {
      ST_FILL,
      ST_ROW,
      ST_COL,
      ST_EMIT
   } state_type;

   // command to the serial multiply-accumulate unit
   typedef struct packed {
      logic    start;
      logic    clear;
      mid_type operand;
      coef_type coef;
   } mac_cmd_type;

   typedef struct packed {
      logic    done;
      acc_type acc;
   } mac_rsp_type;

   function automatic logic signed [31:0] half_cos_q16(input logic [3:0] k);
      case (k)
         4'd0:    half_cos_q16 = 32'sd32768;
         4'd1:    half_cos_q16 = 32'sd32138;
         4'd2:    half_cos_q16 = 32'sd30274;
         4'd3:    half_cos_q16 = 32'sd27246;
         4'd4:    half_cos_q16 = 32'sd23170;
         4'd5:    half_cos_q16 = 32'sd18205;
         4'd6:    half_cos_q16 = 32'sd12540;
         4'd7:    half_cos_q16 = 32'sd6393;
         default: half_cos_q16 = 32'sd0;
      endcase
   endfunction

   // K[u][x] in Q1.COS_FRAC_BITS
   function automatic coef_type basis(input logic [2:0] u, input logic [2:0] x);
      logic [4:0]         k;
      logic signed [31:0] q16;
      logic signed [31:0] r;
      k = 5'((({2'b0, x} << 1) + 5'd1) * {2'b0, u});
      if (k > 5'd16) k = 5'(6'd32 - {1'b0, k});
      if (u == 3'd0) q16 = half_cos_q16(4'd4);
      else if (k > 5'd8) q16 = -half_cos_q16(4'(5'd16 - k));
      else q16 = half_cos_q16(k[3:0]);
      if (COS_FRAC_BITS >= 16) r = q16 <<< (COS_FRAC_BITS - 16);
      else r = (q16 + (32'sd1 <<< (15 - COS_FRAC_BITS))) >>> (16 - COS_FRAC_BITS);
      basis = COEF_WIDTH'(r);
   endfunction

endpackage

// ===== design/ram_generic.sv =====
// Generic single-port-write, one-read RAM with registered read data.
module ram_generic #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== design/dct_mac.sv =====
// Bit-serial multiply-accumulate: one coefficient bit per cycle.
module dct_mac (
   input  logic                 clock,
   input  logic                 reset,
   input  dct_pkg::mac_cmd_type cmd,
   output dct_pkg::mac_rsp_type rsp
);
   import dct_pkg::*;

   acc_type                  acc_ff, acc_in;
   acc_type                  prod_ff, prod_in;
   acc_type                  mcand_ff, mcand_in;
   logic [COEF_WIDTH-1:0]    mplier_ff, mplier_in;
   logic [BIT_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic                     last_bit;

   assign last_bit = cnt_ff == BIT_CNT_WIDTH'(COEF_WIDTH - 1);

   always_comb begin
      acc_in    = acc_ff;
      prod_in   = prod_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (cmd.start) begin
         if (cmd.clear) acc_in = '0;
         prod_in   = '0;
         mcand_in  = ACC_WIDTH'(cmd.operand);
         mplier_in = cmd.coef;
         cnt_in    = '0;
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         // sign bit of the coefficient carries negative weight
         if (mplier_ff[0]) begin
            if (last_bit) prod_in = prod_ff - mcand_ff;
            else prod_in = prod_ff + mcand_ff;
         end
         mcand_in  = mcand_ff <<< 1;
         mplier_in = mplier_ff >> 1;
         cnt_in    = cnt_ff + 1'b1;
         if (last_bit) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (done_ff) begin
         acc_in = acc_ff + prod_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff    <= acc_in;
      prod_ff   <= prod_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

   // acc valid in the cycle after done (accumulate happens then)
   logic acc_ready_ff;
   always_ff @(posedge clock) begin
      if (reset) acc_ready_ff <= 1'b0;
      else acc_ready_ff <= done_ff;
   end
   assign rsp.done = acc_ready_ff;
   assign rsp.acc  = acc_ff;
endmodule

// ===== design/dct_8x8_2d_forward_inverse.sv =====
// Top level: 8x8 2-D DCT / inverse DCT with bit-serial shared MAC.
// Each MAC steps through read, start, the coefficient bits one by one, accumulate and done;
// 1024 MACs per block, after which the 64 results follow, one per cycle.
// Busy stays high from the 64th request until the results are out; a new request is
// taken in the cycle of the last result. Reset (synchronous): fill count, mode, state clear.
module dct_8x8_2d_forward_inverse (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [dct_pkg::SAMPLE_WIDTH-1:0] req_sample_value,
   output logic                          rsp_strobe,
   output logic signed [dct_pkg::RESULT_WIDTH-1:0] rsp_result_value,
   output logic                          rsp_last_of_block,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_inverse_mode
);
   import dct_pkg::*;

   state_type   state_ff, state_in;
   logic [5:0]  fill_ff, fill_in;
   logic        mode_ff;
   logic [2:0]  i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic        phase_ff, phase_in;   // 0: issue read, 1: operand available
   logic        wait_ff, wait_in;     // MAC running
   logic [5:0]  emit_ff, emit_in;
   logic        accept;

   mac_cmd_type cmd;
   mac_rsp_type mrsp;

   logic        st_we, md_we;
   logic [5:0]  st_waddr, st_raddr, md_waddr, md_raddr;
   logic [SAMPLE_WIDTH-1:0] st_rdata;
   logic [MID_WIDTH-1:0]    md_wdata, md_rdata;
   logic [RESULT_WIDTH-1:0] out_wdata, out_rdata;
   logic        out_we;
   logic [5:0]  out_waddr;
   acc_type     rnd;

   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign busy      = state_ff != ST_FILL;

   always_ff @(posedge clock) begin
      if (reset) mode_ff <= 1'b0;
      else if (csr_valid && csr_ready) mode_ff <= csr_inverse_mode;
   end

   assign st_we    = accept;
   assign st_waddr = fill_ff;

   ram_generic #(.WIDTH(SAMPLE_WIDTH), .DEPTH(BLK2)) u_store (
      .clock, .wr_en(st_we), .wr_addr(st_waddr), .wr_data(req_sample_value),
      .rd_addr(st_raddr), .rd_data(st_rdata));
   ram_generic #(.WIDTH(MID_WIDTH), .DEPTH(BLK2)) u_mid (
      .clock, .wr_en(md_we), .wr_addr(md_waddr), .wr_data(md_wdata),
      .rd_addr(md_raddr), .rd_data(md_rdata));
   ram_generic #(.WIDTH(RESULT_WIDTH), .DEPTH(BLK2)) u_out (
      .clock, .wr_en(out_we), .wr_addr(out_waddr), .wr_data(out_wdata),
      .rd_addr(emit_ff), .rd_data(out_rdata));

   dct_mac u_mac (.clock, .reset, .cmd, .rsp(mrsp));

   // row pass reads store[i][k]; column pass reads mid[k][j]
   assign st_raddr = {i_ff, k_ff};
   assign md_raddr = {k_ff, j_ff};

   // rounding of the finished sum
   assign rnd = (mrsp.acc + (ACC_WIDTH'(1) <<< (COS_FRAC_BITS - 1))) >>> COS_FRAC_BITS;

   always_comb begin
      md_we     = state_ff == ST_ROW && wait_ff && mrsp.done && k_ff == 3'd7;
      md_waddr  = {i_ff, j_ff};
      md_wdata  = MID_WIDTH'(rnd);
      out_we    = state_ff == ST_COL && wait_ff && mrsp.done && k_ff == 3'd7;
      out_waddr = {i_ff, j_ff};
      if (rnd > ACC_WIDTH'(32767)) out_wdata = 16'sh7fff;
      else if (rnd < -ACC_WIDTH'(32768)) out_wdata = 16'sh8000;
      else out_wdata = RESULT_WIDTH'(rnd);
   end

   // store write index and next-state logic
   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      i_in = i_ff; j_in = j_ff; k_in = k_ff;
      phase_in = phase_ff;
      wait_in  = wait_ff;
      emit_in  = emit_ff;
      case (state_ff)
         ST_FILL: begin
            if (accept) begin
               fill_in = fill_ff + 1'b1;
               if (fill_ff == 6'd63) begin
                  state_in = ST_ROW;
                  i_in = '0; j_in = '0; k_in = '0;
                  phase_in = 1'b0; wait_in = 1'b0;
               end
            end
         end
         ST_ROW, ST_COL: begin
            if (wait_ff) begin
               if (mrsp.done) begin
                  wait_in = 1'b0;
                  k_in = k_ff + 1'b1;
                  if (k_ff == 3'd7) begin
                     // sum is written this cycle; move to next output
                     j_in = j_ff + 1'b1;
                     if (j_ff == 3'd7) begin
                        i_in = i_ff + 1'b1;
                        if (i_ff == 3'd7) begin
                           if (state_ff == ST_ROW) state_in = ST_COL;
                           else begin
                              state_in = ST_EMIT;
                              emit_in  = '0;
                           end
                        end
                     end
                  end
               end
            end else if (!phase_ff) begin
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               wait_in  = 1'b1;
            end
         end
         ST_EMIT: begin
            emit_in = emit_ff + 1'b1;
            if (emit_ff == 6'd63) state_in = ST_FILL;
         end
         default: state_in = ST_FILL;
      endcase
   end

   // MAC command
   always_comb begin
      cmd.start   = (state_ff == ST_ROW || state_ff == ST_COL) && !wait_ff && phase_ff;
      cmd.clear   = k_ff == 3'd0;
      if (state_ff == ST_ROW) begin
         cmd.operand = MID_WIDTH'(signed'(st_rdata));
         cmd.coef    = mode_ff ? basis(k_ff, j_ff) : basis(j_ff, k_ff);
      end else begin
         cmd.operand = md_rdata;
         cmd.coef    = mode_ff ? basis(k_ff, i_ff) : basis(i_ff, k_ff);
      end
   end

   // outputs: read data arrives in the cycle after its emit address
   logic       emit_v_ff;
   logic [5:0] emit_idx_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_FILL;
         fill_ff   <= '0;
         wait_ff   <= 1'b0;
         phase_ff  <= 1'b0;
         emit_v_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         wait_ff   <= wait_in;
         phase_ff  <= phase_in;
         emit_v_ff <= state_ff == ST_EMIT;
      end
      i_ff <= i_in; j_ff <= j_in; k_ff <= k_in;
      emit_ff     <= emit_in;
      emit_idx_ff <= emit_ff;
   end

   assign rsp_strobe        = emit_v_ff;
   assign rsp_result_value  = out_rdata;
   assign rsp_last_of_block = emit_v_ff && emit_idx_ff == 6'd63;
endmodule

// ===== design/dct_checker.sv =====
// Port-level checker for the DCT block, bound to the top level.
module dct_checker (
   input logic clock,
   input logic reset,
   input logic busy,
   input logic rsp_strobe,
   input logic rsp_last_of_block
);
   a_last_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_last_of_block |-> rsp_strobe) else $error("last without strobe");
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_of_block |-> busy) else $error("result while idle");
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_last_of_block |=> !rsp_strobe) else $error("result after last");
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      !busy && !$past(busy) |-> !rsp_strobe) else $error("strobe when idle");
endmodule

bind dct_8x8_2d_forward_inverse dct_checker u_dct_checker (
   .clock, .reset, .busy, .rsp_strobe, .rsp_last_of_block);

// ===== tb/sv/dct_checker.sv =====
// Checker for the 8x8 DCT block: rebuilds each block, predicts its results, compares them.
module dct_scoreboard (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  dct_pkg::sample_type req_sample_value,
   input  logic                rsp_strobe,
   input  dct_pkg::result_type rsp_result_value,
   input  logic                rsp_last_of_block,
   input  logic                csr_valid,
   input  logic                csr_ready,
   input  logic                csr_inverse_mode,
   output int                  error_count,
   output int                  pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import dct_pkg::*;

   typedef struct {
      result_type value;
      logic       last;
   } dct_result_type;

   // half cosines cos(k*pi/16) in Q1.16
   localparam int HALF_COS [0:8] = '{32768, 32138, 30274, 27246, 23170, 18205, 12540, 6393, 0};

   longint         coef_rom [0:7][0:7];
   longint         pixel_buf [0:63];
   int             fill_idx;
   logic           mode_inv;
   dct_result_type result_fifo [$];

   assign pending_count = result_fifo.size();

   function automatic longint round_q(input longint v);
      return (v + (64'sd1 <<< (COS_FRAC_BITS - 1))) >>> COS_FRAC_BITS;
   endfunction

   initial begin
      for (int u = 0; u < 8; u++) begin
         for (int x = 0; x < 8; x++) begin
            int     k;
            longint q;
            k = ((2 * x + 1) * u) % 32;
            if (k > 16) k = 32 - k;
            if (u == 0) q = HALF_COS[4];
            else if (k > 8) q = -HALF_COS[16 - k];
            else q = HALF_COS[k];
            // Q1.16 down to the coefficient precision, round half up
            coef_rom[u][x] = (q + (64'sd1 <<< (15 - COS_FRAC_BITS))) >>> (16 - COS_FRAC_BITS);
         end
      end
   end

   task automatic predict_block();
      longint         mid [0:7][0:7];
      longint         acc;
      longint         r;
      dct_result_type e;
      for (int i = 0; i < 8; i++) begin
         for (int j = 0; j < 8; j++) begin
            acc = 0;
            for (int k = 0; k < 8; k++)
               acc += pixel_buf[i*8+k] * (mode_inv ? coef_rom[k][j] : coef_rom[j][k]);
            mid[i][j] = round_q(acc);
         end
      end
      for (int i = 0; i < 8; i++) begin
         for (int j = 0; j < 8; j++) begin
            acc = 0;
            for (int k = 0; k < 8; k++)
               acc += (mode_inv ? coef_rom[k][i] : coef_rom[i][k]) * mid[k][j];
            r = round_q(acc);
            if (r > 32767) r = 32767;
            if (r < -32768) r = -32768;
            e.value = result_type'(r);
            e.last  = (i == 7 && j == 7);
            result_fifo.push_back(e);
         end
      end
   endtask

   always @(posedge clock) begin
      dct_result_type e;
      if (reset) begin
         fill_idx    <= 0;
         mode_inv    = 1'b0;
         error_count <= 0;
         result_fifo.delete();
      end else begin
         if (csr_valid && csr_ready) mode_inv = csr_inverse_mode;
         if (start && !busy) begin
            pixel_buf[fill_idx] = longint'(req_sample_value);
            if (fill_idx == 63) begin
               fill_idx <= 0;
               predict_block();
            end else begin
               fill_idx <= fill_idx + 1;
            end
         end
         if (rsp_strobe) begin
            if (result_fifo.size() == 0) begin
               $display("%0t: unexpected result value=%0d last=%0b", $time,
                        rsp_result_value, rsp_last_of_block);
               error_count <= error_count + 1;
            end else begin
               e = result_fifo.pop_front();
               if (e.value !== rsp_result_value || e.last !== rsp_last_of_block) begin
                  $display("%0t: mismatch expected value=%0d last=%0b, actual value=%0d last=%0b",
                           $time, e.value, e.last, rsp_result_value, rsp_last_of_block);
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end

endmodule

// ===== tb/sv/tb.sv =====
// Top of the DCT testbench: clock, reset, request and mode stimulus, verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import dct_pkg::*;

   localparam int IDLE_LIMIT = 100000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   sample_type req_sample_value = '0;
   logic       rsp_strobe;
   result_type rsp_result_value;
   logic       rsp_last_of_block;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_inverse_mode = 1'b0;
   int         error_count;
   int         pending_count;
   int         quiet_cycles = 0;
   int         gap_pct = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   dct_8x8_2d_forward_inverse dut (.*);

   dct_scoreboard checker_i (.*);

   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe || (csr_valid && csr_ready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic write_mode(input logic inv);
      logic rdy;
      @(negedge clock);
      csr_valid        <= 1'b1;
      csr_inverse_mode <= inv;
      forever begin
         rdy = csr_ready;
         @(posedge clock);
         if (rdy) break;
         @(negedge clock);
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // one request; random gaps before it per the current phase
   task automatic send_sample(input sample_type v);
      logic bsy;
      while ($urandom_range(99) < gap_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start            <= 1'b1;
      req_sample_value <= v;
      forever begin
         bsy = busy;
         @(posedge clock);
         if (!bsy) break;
         @(negedge clock);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   initial begin
      sample_type edge_vals [0:9];
      edge_vals = '{12'sh800, 12'sd2047, 12'sd0, -12'sd1, 12'sd1,
                    12'sh555, 12'shAAA, 12'sd1024, -12'sd1024, 12'sd2047};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // forward: directed extremes then random; no gaps, then sender idle, then mixed
      write_mode(1'b0);
      for (int i = 0; i < 64; i++) begin
         gap_pct = (i < 22) ? 0 : ((i < 43) ? 74 : 35);
         send_sample(i < 10 ? edge_vals[i] : (i < 20 ? sample_type'(12'sd2047)
                     : sample_type'($urandom)));
      end
      drain();

      // inverse with only full-scale values, drives saturation
      write_mode(1'b1);
      for (int i = 0; i < 64; i++) begin
         gap_pct = (i < 22) ? 74 : ((i < 43) ? 35 : 0);
         send_sample($urandom_range(1) ? sample_type'(12'sd2047) : sample_type'(12'sh800));
      end
      drain();

      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
